// File: src/iee_pkg.sv
// ----------------------------------------------------------------------------
// iee_pkg: shared types and constants of the infix expression evaluator
// Operator codes, ASCII codes and the request/response bundle of the ALU.
// ----------------------------------------------------------------------------
package iee_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int VALUE_WIDTH    = 32;
    localparam int CHAR_WIDTH     = 8;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    localparam logic [CHAR_WIDTH-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_WIDTH-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_WIDTH-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_WIDTH-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_WIDTH-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_WIDTH-1:0] CH_STAR  = 8'h2A;
    localparam logic [CHAR_WIDTH-1:0] CH_SLASH = 8'h2F;

    typedef struct packed {
        logic start;
        t_op  op;
    } t_alu_req;

    typedef struct packed {
        logic done;
        logic busy;
    } t_alu_rsp;

endpackage

// File: src/iee_alu.sv
// ----------------------------------------------------------------------------
// iee_alu: shared multi-cycle arithmetic unit
// Add and subtract are registered; multiply by shift-and-add one bit per cycle,
// divide by restoring division one quotient bit per cycle, truncating to zero.
// ----------------------------------------------------------------------------
module iee_alu #(
    parameter int DATA_WIDTH = iee_pkg::DATA_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  iee_pkg::t_alu_req     i_req,
    input  logic [DATA_WIDTH-1:0] i_a,
    input  logic [DATA_WIDTH-1:0] i_b,
    output iee_pkg::t_alu_rsp     o_rsp,
    output logic [DATA_WIDTH-1:0] o_result
);

    localparam int CNT_W = $clog2(DATA_WIDTH);

    typedef enum logic [1:0] {
        A_IDLE,
        A_MUL,
        A_DIV,
        A_DIV_FIX
    } t_alu_state;

    t_alu_state              r_state, n_state;
    logic                    r_done, n_done;
    logic [DATA_WIDTH-1:0]   r_acc, n_acc;
    logic [DATA_WIDTH-1:0]   r_x, n_x;
    logic [DATA_WIDTH-1:0]   r_y, n_y;
    logic [DATA_WIDTH-1:0]   r_d, n_d;
    logic                    r_neg, n_neg;
    logic [CNT_W-1:0]        r_cnt, n_cnt;

    logic [DATA_WIDTH-1:0]   w_mag_a, w_mag_b;
    logic [DATA_WIDTH:0]     w_trial, w_diff;
    logic                    w_fits;

    assign w_mag_a = i_a[DATA_WIDTH-1] ? (~i_a + 1'b1) : i_a;
    assign w_mag_b = i_b[DATA_WIDTH-1] ? (~i_b + 1'b1) : i_b;
    assign w_trial = {r_x, r_y[DATA_WIDTH-1]};
    assign w_diff  = w_trial - {1'b0, r_d};
    assign w_fits  = (w_trial >= {1'b0, r_d});

    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        n_acc   = r_acc;
        n_x     = r_x;
        n_y     = r_y;
        n_d     = r_d;
        n_neg   = r_neg;
        n_cnt   = r_cnt;
        unique case (r_state)
            A_IDLE: begin
                if (i_req.start) begin
                    n_cnt = CNT_W'(DATA_WIDTH - 1);
                    unique case (i_req.op)
                        iee_pkg::OP_ADD: begin
                            n_acc  = i_a + i_b;
                            n_done = 1'b1;
                        end
                        iee_pkg::OP_SUB: begin
                            n_acc  = i_a - i_b;
                            n_done = 1'b1;
                        end
                        iee_pkg::OP_MUL: begin
                            n_acc   = '0;
                            n_x     = i_a;
                            n_y     = i_b;
                            n_state = A_MUL;
                        end
                        iee_pkg::OP_DIV: begin
                            n_x     = '0;
                            n_y     = w_mag_a;
                            n_d     = w_mag_b;
                            n_neg   = i_a[DATA_WIDTH-1] ^ i_b[DATA_WIDTH-1];
                            n_state = A_DIV;
                        end
                        default: n_state = A_IDLE;
                    endcase
                end
            end
            A_MUL: begin
                if (r_y[0]) begin
                    n_acc = r_acc + r_x;
                end
                n_x   = {r_x[DATA_WIDTH-2:0], 1'b0};
                n_y   = {1'b0, r_y[DATA_WIDTH-1:1]};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_done  = 1'b1;
                    n_state = A_IDLE;
                end
            end
            A_DIV: begin
                // shift in the next dividend bit, keep the difference if it fits
                n_x   = w_fits ? w_diff[DATA_WIDTH-1:0] : w_trial[DATA_WIDTH-1:0];
                n_y   = {r_y[DATA_WIDTH-2:0], w_fits};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = A_DIV_FIX;
                end
            end
            A_DIV_FIX: begin
                n_acc   = r_neg ? (~r_y + 1'b1) : r_y;
                n_done  = 1'b1;
                n_state = A_IDLE;
            end
            default: n_state = A_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_acc <= n_acc;
        r_x   <= n_x;
        r_y   <= n_y;
        r_d   <= n_d;
        r_neg <= n_neg;
        r_cnt <= n_cnt;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.busy = (r_state != A_IDLE);
    assign o_result   = r_acc;

endmodule

// File: src/infix_expression_evaluator.sv
// ----------------------------------------------------------------------------
// infix_expression_evaluator: streaming evaluator of + - * / expressions
// Sequencer with shift-register operand and operator stacks driving one
// shared multi-cycle ALU.
// ----------------------------------------------------------------------------
// Usage:
//   Input requests carry one ASCII character (i_character) and i_last, which
//   marks the final character. A request is taken on a clock edge with
//   i_valid high and o_stall low. o_stall is high while a character is being
//   worked on.
//   A digit, space or bad character leaves o_stall low unless it is last. An
//   operator runs the operator loop plus up to two reductions, each on the
//   shared ALU, which multiplies and divides one bit per cycle. A last
//   character runs its final reductions and may also wait for a stalled
//   result ahead of it.
//   The last character produces one output request (o_value, o_error) held
//   in an output register until taken (o_valid high, i_stall low). Input is
//   taken while that result waits; a second result waits for the first.
//   On error, o_value is 0 and o_error is 1.
//   Reset (synchronous, active low) clears the number, counts and error.
// ----------------------------------------------------------------------------
module infix_expression_evaluator #(
    parameter int DATA_WIDTH = iee_pkg::DATA_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [iee_pkg::CHAR_WIDTH-1:0]      i_character,
    input  logic                                i_last,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [iee_pkg::VALUE_WIDTH-1:0] o_value,
    output logic                                o_error
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_OPLOOP,
        S_ALU,
        S_FINISH,
        S_FINLOOP
    } t_state;

    t_state                  r_state, n_state;
    logic [DATA_WIDTH-1:0]   r_num, n_num;
    logic                    r_digit, n_digit;
    logic                    r_err, n_err;
    logic [1:0]              r_val_cnt, n_val_cnt;
    logic [1:0]              r_op_cnt, n_op_cnt;
    logic                    r_last, n_last;
    logic                    r_final, n_final;
    iee_pkg::t_op            r_pend_op, n_pend_op;
    logic [DATA_WIDTH-1:0]   r_vs0, n_vs0;
    logic [DATA_WIDTH-1:0]   r_vs1, n_vs1;
    logic [DATA_WIDTH-1:0]   r_vs2, n_vs2;
    iee_pkg::t_op            r_os0, n_os0;
    iee_pkg::t_op            r_os1, n_os1;
    logic                    r_out_valid, n_out_valid;
    logic [iee_pkg::VALUE_WIDTH-1:0] r_out_value, n_out_value;
    logic                    r_out_error, n_out_error;

    iee_pkg::t_alu_req       w_alu_req;
    iee_pkg::t_alu_rsp       w_alu_rsp;
    logic [DATA_WIDTH-1:0]   w_alu_result;
    logic [DATA_WIDTH-1:0]   w_num_next;
    logic [iee_pkg::VALUE_WIDTH-1:0] w_top_value;
    logic                    w_accept;
    logic                    w_reduce_bad;
    logic                    w_div_zero;
    logic                    w_top_high;
    logic                    w_pend_low;

    iee_alu #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (w_alu_req),
        .i_a      (r_vs1),
        .i_b      (r_vs0),
        .o_rsp    (w_alu_rsp),
        .o_result (w_alu_result)
    );

    generate
        if (DATA_WIDTH >= iee_pkg::VALUE_WIDTH) begin : g_out_trunc
            assign w_top_value = r_vs0[iee_pkg::VALUE_WIDTH-1:0];
        end else begin : g_out_ext
            assign w_top_value = {{(iee_pkg::VALUE_WIDTH - DATA_WIDTH){1'b0}}, r_vs0};
        end
    endgenerate

    assign w_accept     = i_valid && !o_stall;
    assign w_num_next   = {r_num[DATA_WIDTH-4:0], 3'b000} + {r_num[DATA_WIDTH-2:0], 1'b0}
                          + DATA_WIDTH'(i_character[3:0]);
    assign w_reduce_bad = (r_val_cnt < 2'd2) || (r_op_cnt == 2'd0);
    assign w_div_zero   = (r_os0 == iee_pkg::OP_DIV) && (r_vs0 == '0);
    assign w_top_high   = (r_os0 == iee_pkg::OP_MUL) || (r_os0 == iee_pkg::OP_DIV);
    assign w_pend_low   = (r_pend_op == iee_pkg::OP_ADD) || (r_pend_op == iee_pkg::OP_SUB);

    always_comb begin
        n_state     = r_state;
        n_num       = r_num;
        n_digit     = r_digit;
        n_err       = r_err;
        n_val_cnt   = r_val_cnt;
        n_op_cnt    = r_op_cnt;
        n_last      = r_last;
        n_final     = r_final;
        n_pend_op   = r_pend_op;
        n_vs0       = r_vs0;
        n_vs1       = r_vs1;
        n_vs2       = r_vs2;
        n_os0       = r_os0;
        n_os1       = r_os1;
        n_out_valid = r_out_valid && i_stall;
        n_out_value = r_out_value;
        n_out_error = r_out_error;
        w_alu_req.start = 1'b0;
        w_alu_req.op    = r_os0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_last = i_last;
                    if (!r_err) begin
                        case (i_character) inside
                            [iee_pkg::CH_ZERO:iee_pkg::CH_NINE]: begin
                                n_num   = w_num_next;
                                n_digit = 1'b1;
                            end
                            iee_pkg::CH_SPACE: begin
                            end
                            iee_pkg::CH_PLUS, iee_pkg::CH_MINUS,
                            iee_pkg::CH_STAR, iee_pkg::CH_SLASH: begin
                                if (!r_digit) begin
                                    n_err = 1'b1;
                                end else begin
                                    if (r_val_cnt == 2'd3) begin
                                        n_err = 1'b1;
                                    end else begin
                                        n_vs2     = r_vs1;
                                        n_vs1     = r_vs0;
                                        n_vs0     = r_num;
                                        n_val_cnt = r_val_cnt + 2'd1;
                                        n_num     = '0;
                                        n_digit   = 1'b0;
                                    end
                                    n_state = S_OPLOOP;
                                end
                                case (i_character)
                                    iee_pkg::CH_PLUS:  n_pend_op = iee_pkg::OP_ADD;
                                    iee_pkg::CH_MINUS: n_pend_op = iee_pkg::OP_SUB;
                                    iee_pkg::CH_STAR:  n_pend_op = iee_pkg::OP_MUL;
                                    default:           n_pend_op = iee_pkg::OP_DIV;
                                endcase
                            end
                            default: n_err = 1'b1;
                        endcase
                    end
                    if (n_state == S_IDLE && i_last) begin
                        n_state = S_FINISH;
                    end
                end
            end
            S_OPLOOP: begin
                if (r_err) begin
                    n_state = r_last ? S_FINISH : S_IDLE;
                end else if (r_op_cnt != 2'd0 && (w_top_high || w_pend_low)) begin
                    if (w_reduce_bad || w_div_zero) begin
                        n_err = 1'b1;
                    end else begin
                        w_alu_req.start = 1'b1;
                        n_final         = 1'b0;
                        n_state         = S_ALU;
                    end
                end else begin
                    if (r_op_cnt >= 2'd2) begin
                        n_err = 1'b1;
                    end else begin
                        n_os1    = r_os0;
                        n_os0    = r_pend_op;
                        n_op_cnt = r_op_cnt + 2'd1;
                    end
                    n_state = r_last ? S_FINISH : S_IDLE;
                end
            end
            S_ALU: begin
                // pop both operands and the operator, push the result
                if (w_alu_rsp.done) begin
                    n_vs0     = w_alu_result;
                    n_vs1     = r_vs2;
                    n_os0     = r_os1;
                    n_val_cnt = r_val_cnt - 2'd1;
                    n_op_cnt  = r_op_cnt - 2'd1;
                    n_state   = r_final ? S_FINLOOP : S_OPLOOP;
                end
            end
            S_FINISH: begin
                if (!r_err) begin
                    if (!r_digit || r_val_cnt == 2'd3) begin
                        n_err = 1'b1;
                    end else begin
                        n_vs2     = r_vs1;
                        n_vs1     = r_vs0;
                        n_vs0     = r_num;
                        n_val_cnt = r_val_cnt + 2'd1;
                    end
                end
                n_final = 1'b1;
                n_state = S_FINLOOP;
            end
            S_FINLOOP: begin
                if (!r_err && r_op_cnt != 2'd0) begin
                    if (w_reduce_bad || w_div_zero) begin
                        n_err = 1'b1;
                    end else begin
                        w_alu_req.start = 1'b1;
                        n_state         = S_ALU;
                    end
                end else if (!r_out_valid || !i_stall) begin
                    // hand off the result and return to the reset state
                    n_out_valid = 1'b1;
                    n_out_value = r_err ? '0 : w_top_value;
                    n_out_error = r_err;
                    n_num       = '0;
                    n_digit     = 1'b0;
                    n_err       = 1'b0;
                    n_val_cnt   = 2'd0;
                    n_op_cnt    = 2'd0;
                    n_last      = 1'b0;
                    n_final     = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_num       <= '0;
            r_digit     <= 1'b0;
            r_err       <= 1'b0;
            r_val_cnt   <= 2'd0;
            r_op_cnt    <= 2'd0;
            r_last      <= 1'b0;
            r_final     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_num       <= n_num;
            r_digit     <= n_digit;
            r_err       <= n_err;
            r_val_cnt   <= n_val_cnt;
            r_op_cnt    <= n_op_cnt;
            r_last      <= n_last;
            r_final     <= n_final;
            r_out_valid <= n_out_valid;
        end
        r_pend_op   <= n_pend_op;
        r_vs0       <= n_vs0;
        r_vs1       <= n_vs1;
        r_vs2       <= n_vs2;
        r_os0       <= n_os0;
        r_os1       <= n_os1;
        r_out_value <= n_out_value;
        r_out_error <= n_out_error;
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;
    assign o_value = r_out_value;
    assign o_error = r_out_error;

    // Between characters every pushed operator waits on exactly one more operand
    a_stack_balance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && !r_err) |-> (r_val_cnt == r_op_cnt))
        else $error("operand and operator counts out of step");

    a_alu_start_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_alu_req.start |-> !w_alu_rsp.busy)
        else $error("ALU started while busy");

    a_alu_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_alu_rsp.done |-> (r_state == S_ALU))
        else $error("ALU result arrived with no reduction pending");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_error) |-> (o_value == '0))
        else $error("error result carries a nonzero value");

endmodule
